// ===== hw/rtl/srm_pkg.sv =====
package srm_pkg;

	// Default sizes of the table.
	localparam int TABLE_ROWS_DEF  = 256;
	localparam int MAX_COLUMNS_DEF = 8;

	// Fixed field widths.
	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 64;
	localparam int CFG_W    = 4;
	localparam int INDEX_W  = 8;

	// Input item operations.
	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// Outcome of comparing one query element with one table element.
	typedef enum logic [1:0] {
		CMP_EQUAL,
		CMP_LESS,
		CMP_ADVANCE
	} cmp_t;

endpackage

// ===== hw/rtl/srm_ram.sv =====
module srm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/srm_cmp.sv =====
module srm_cmp (
	input  logic [srm_pkg::VALUE_W-1:0] query_elem,
	input  logic [srm_pkg::VALUE_W-1:0] table_elem,
	output srm_pkg::cmp_t               outcome
);

	logic       nan_q_e, nan_t_e, inf_q_e, inf_t_e;
	logic       both_zero, mag_less, q_less;
	logic [62:0] mag_q, mag_t;

	assign mag_q     = query_elem[62:0];
	assign mag_t     = table_elem[62:0];
	assign nan_q_e   = (query_elem[62:52] == 11'h7ff) && (query_elem[51:0] != 52'd0);
	assign nan_t_e   = (table_elem[62:52] == 11'h7ff) && (table_elem[51:0] != 52'd0);
	assign inf_q_e   = (query_elem[62:52] == 11'h7ff) && (query_elem[51:0] == 52'd0);
	assign inf_t_e   = (table_elem[62:52] == 11'h7ff) && (table_elem[51:0] == 52'd0);
	assign both_zero = (mag_q == 63'd0) && (mag_t == 63'd0);
	assign mag_less  = mag_q < mag_t;

	// Ordered comparison of two sign-magnitude values that are not both zero.
	always_comb begin
		if (query_elem[63] != table_elem[63]) begin
			q_less = query_elem[63];
		end else if (query_elem[63]) begin
			q_less = !mag_less && (mag_q != mag_t);
		end else begin
			q_less = mag_less;
		end
	end

	// The sign of the difference: any NaN operand, or an infinity minus the same infinity, advances the row.
	always_comb begin
		if (nan_q_e || nan_t_e) begin
			outcome = srm_pkg::CMP_ADVANCE;
		end else if (inf_q_e && inf_t_e && (query_elem[63] == table_elem[63])) begin
			outcome = srm_pkg::CMP_ADVANCE;
		end else if (both_zero || (query_elem == table_elem)) begin
			outcome = srm_pkg::CMP_EQUAL;
		end else if (q_less) begin
			outcome = srm_pkg::CMP_LESS;
		end else begin
			outcome = srm_pkg::CMP_ADVANCE;
		end
	end

endmodule

// ===== hw/rtl/sorted_row_merge_match.sv =====
// Merge-join lookup of sorted query rows in a sorted table of double rows.
// Input channel (in_valid, in_stall, opcode, value): each item is a clear,
// one table element or one query element, column 0 first. The table and the
// queries must both be sorted ascending. Output channel (out_valid, out_stall,
// found, row_index) carries one item for every completed query row.
// Configuration channel (cfg_valid, cfg_ready, num_columns) sets the column
// count and is always ready; write it only while the block is idle.
// Clear, load and non-final query items are taken while the block is idle.
// The final element of a query row starts a search that reads the table one
// element at a time: a bound check with the registered memory read, then a
// compare. The end of the table, a lesser query element or a full row match
// ends it and the result is posted. in_stall is high for the whole search.
// A pending result waits in the output register while later clears and
// loads are taken; a further search holds its result until out_stall falls.
// Reset empties the table, the query and the output and sets the column count
// to one; the table memory itself is not cleared.
module sorted_row_merge_match #(
	parameter int TABLE_ROWS  = srm_pkg::TABLE_ROWS_DEF,
	parameter int MAX_COLUMNS = srm_pkg::MAX_COLUMNS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [srm_pkg::OPCODE_W-1:0]  opcode,
	input  logic [srm_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [srm_pkg::INDEX_W-1:0]   row_index,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srm_pkg::CFG_W-1:0]     num_columns
);

	localparam int RW  = $clog2(TABLE_ROWS + 1);
	localparam int RA  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int CNW = $clog2(MAX_COLUMNS + 1);
	localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int AW  = RA + CW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_COMPARE,
		ST_POST
	} state_t;

	state_t                          state_q;
	logic [srm_pkg::CFG_W-1:0]       ncol_q;
	logic [RW-1:0]                   count_q;
	logic [RW-1:0]                   pos_q;
	logic [CNW-1:0]                  load_col_q;
	logic [CNW-1:0]                  query_col_q;
	logic [CNW-1:0]                  search_col_q;
	logic [srm_pkg::VALUE_W-1:0]     query_row_q [MAX_COLUMNS];
	logic                            res_found_q;
	logic [srm_pkg::INDEX_W-1:0]     res_index_q;
	logic                            out_valid_q;
	logic                            found_q;
	logic [srm_pkg::INDEX_W-1:0]     row_index_q;

	logic [CNW-1:0]                  cols;
	logic                            accept;
	logic                            do_load;
	logic                            do_query;
	logic                            load_last;
	logic                            query_last;
	logic                            search_last;
	logic [AW-1:0]                   waddr;
	logic [AW-1:0]                   raddr;
	logic [srm_pkg::VALUE_W-1:0]     rdata;
	srm_pkg::cmp_t                   outcome;

	// Effective column count, clamped to the supported range.
	always_comb begin
		if (ncol_q == '0) begin
			cols = CNW'(1);
		end else if (32'(ncol_q) > MAX_COLUMNS) begin
			cols = CNW'(MAX_COLUMNS);
		end else begin
			cols = CNW'(ncol_q);
		end
	end

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign do_load     = accept && (opcode == srm_pkg::OP_LOAD) && (count_q < RW'(TABLE_ROWS));
	assign do_query    = accept && (opcode == srm_pkg::OP_QUERY);
	assign load_last   = ((load_col_q + CNW'(1)) >= cols);
	assign query_last  = ((query_col_q + CNW'(1)) >= cols);
	assign search_last = ((search_col_q + CNW'(1)) >= cols);
	assign waddr       = {count_q[RA-1:0], load_col_q[CW-1:0]};
	assign raddr       = {pos_q[RA-1:0], search_col_q[CW-1:0]};

	// Table memory: row r, column c at entry {r, c}.
	srm_ram #(
		.WIDTH (srm_pkg::VALUE_W),
		.DEPTH (2 ** AW),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (do_load),
		.waddr (waddr),
		.wdata (value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sign of query element minus table element.
	srm_cmp u_cmp (
		.query_elem (query_row_q[search_col_q[CW-1:0]]),
		.table_elem (rdata),
		.outcome    (outcome)
	);

	// Query row elements.
	always_ff @(posedge clk) begin
		if (do_query) begin
			query_row_q[query_col_q[CW-1:0]] <= value;
		end
	end

	// Control, search sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ncol_q       <= srm_pkg::CFG_W'(1);
			count_q      <= '0;
			pos_q        <= '0;
			load_col_q   <= '0;
			query_col_q  <= '0;
			search_col_q <= '0;
			res_found_q  <= 1'b0;
			res_index_q  <= '0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			row_index_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ncol_q <= num_columns;
			end
			if (out_valid_q && !out_stall && (state_q != ST_POST)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == srm_pkg::OP_CLEAR)) begin
						count_q     <= '0;
						pos_q       <= '0;
						load_col_q  <= '0;
						query_col_q <= '0;
					end
					if (do_load) begin
						if (load_last) begin
							load_col_q <= '0;
							count_q    <= count_q + RW'(1);
						end else begin
							load_col_q <= load_col_q + CNW'(1);
						end
					end
					if (do_query) begin
						if (query_last) begin
							query_col_q  <= '0;
							search_col_q <= '0;
							state_q      <= ST_CHECK;
						end else begin
							query_col_q <= query_col_q + CNW'(1);
						end
					end
				end
				ST_CHECK: begin
					// The memory read for {pos, column} is under way.
					if (pos_q >= count_q) begin
						res_found_q <= 1'b0;
						res_index_q <= '0;
						state_q     <= ST_POST;
					end else begin
						state_q <= ST_COMPARE;
					end
				end
				ST_COMPARE: begin
					case (outcome)
						srm_pkg::CMP_LESS: begin
							res_found_q <= 1'b0;
							res_index_q <= '0;
							state_q     <= ST_POST;
						end
						srm_pkg::CMP_EQUAL: begin
							if (search_last) begin
								res_found_q <= 1'b1;
								res_index_q <= srm_pkg::INDEX_W'(pos_q);
								state_q     <= ST_POST;
							end else begin
								search_col_q <= search_col_q + CNW'(1);
								state_q      <= ST_CHECK;
							end
						end
						default: begin
							pos_q        <= pos_q + RW'(1);
							search_col_q <= '0;
							state_q      <= ST_CHECK;
						end
					endcase
				end
				ST_POST: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						found_q     <= res_found_q;
						row_index_q <= res_index_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign row_index = row_index_q;

`ifndef SYNTHESIS
	// The search position never runs beyond the completed rows.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= count_q)
		else $error("search position beyond table row count");

	// A compare always follows a bound check that issued its memory read.
	a_cmp_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |-> $past(state_q == ST_CHECK))
		else $error("compare without a preceding memory read");

	// A not-found result carries a zero row index.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (row_index_q == '0))
		else $error("not-found result with non-zero row index");

	// The table is not written during a search.
	a_no_load_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !do_load)
		else $error("table written while searching");
`endif

endmodule
